// ===== hw/rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
package rsc_pkg;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    localparam logic [1:0] REG_DIST_WEIGHT = 2'd0;
    localparam logic [1:0] REG_GAIN        = 2'd1;
    localparam logic [1:0] REG_BIAS        = 2'd2;
    localparam logic [1:0] REG_EXPONENT    = 2'd3;

    localparam logic [15:0] EXP_UNITY = 16'd4096;
    localparam logic [15:0] EXP_MIN   = 16'd1;

    localparam int SQ_STAGES  = 8;
    localparam int LOG_BITS   = 16;
    localparam int POW_STAGES = 1 + LOG_BITS + 1 + LOG_BITS + 1;
    localparam int LATENCY    = 1 + SQ_STAGES + 3 + POW_STAGES;

    typedef struct packed {
        logic [15:0] gm;
        logic [15:0] att;
    } t_sqrt_tag;

    typedef struct packed {
        logic [15:0] shared;
        logic [15:0] shifted;
        logic        bypass;
    } t_pow_tag;

    function automatic logic [15:0] sat_one(input logic [15:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n   = n_in;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // factor 2^(-2^-k) in Q1.30, built by repeated square roots
    function automatic logic [30:0] exp_const(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int j = 1; j < k; j++) begin
            c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

endpackage

// ===== hw/rtl/rsc_sqrt.sv =====
`timescale 1ns / 1ps
module rsc_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [31:0]          i_n,
    input  rsc_pkg::t_sqrt_tag   i_tag,
    output logic                 o_vld,
    output logic [15:0]          o_root,
    output rsc_pkg::t_sqrt_tag   o_tag
);

    localparam int S = rsc_pkg::SQ_STAGES;

    logic               r_vld [0:S-1];
    logic [31:0]        r_n   [0:S-1];
    logic [31:0]        r_res [0:S-1];
    rsc_pkg::t_sqrt_tag r_tag [0:S-1];

    for (genvar s = 0; s < S; s++) begin : g_st
        logic               a_vld;
        logic [31:0]        a_n;
        logic [31:0]        a_res;
        rsc_pkg::t_sqrt_tag a_tag;
        logic [31:0]        n_n;
        logic [31:0]        n_res;

        if (s == 0) begin : g_first
            assign a_vld = i_vld;
            assign a_n   = i_n;
            assign a_res = '0;
            assign a_tag = i_tag;
        end else begin : g_next
            assign a_vld = r_vld[s-1];
            assign a_n   = r_n[s-1];
            assign a_res = r_res[s-1];
            assign a_tag = r_tag[s-1];
        end

        // two result bits per stage
        always_comb begin
            logic [31:0] b;
            n_n   = a_n;
            n_res = a_res;
            for (int j = 0; j < 2; j++) begin
                b = 32'd1 << (30 - 2 * (2 * s + j));
                if (n_n >= n_res + b) begin
                    n_n   = n_n - (n_res + b);
                    n_res = (n_res >> 1) + b;
                end else begin
                    n_res = n_res >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= a_vld;
            end
            r_n[s]   <= n_n;
            r_res[s] <= n_res;
            r_tag[s] <= a_tag;
        end
    end

    assign o_vld  = r_vld[S-1];
    assign o_root = r_res[S-1][15:0];
    assign o_tag  = r_tag[S-1];

endmodule

// ===== hw/rtl/rsc_pow.sv =====
`timescale 1ns / 1ps
module rsc_pow (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [15:0]        i_x,
    input  logic [15:0]        i_e,
    input  rsc_pkg::t_pow_tag  i_tag,
    output logic               o_vld,
    output logic [15:0]        o_shared,
    output logic [15:0]        o_result
);

    localparam int K = rsc_pkg::LOG_BITS;

    // leading one stage
    logic              r_l_vld;
    logic [30:0]       r_l_m;
    logic [3:0]        r_l_p;
    rsc_pkg::t_pow_tag r_l_tag;

    always_ff @(posedge i_clk) begin
        logic [3:0] p;
        p = '0;
        for (int i = 1; i < 16; i++) begin
            if (i_x[i]) begin
                p = 4'(i);
            end
        end
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else begin
            r_l_vld <= i_vld;
        end
        r_l_m   <= 31'({15'd0, i_x} << (5'd30 - 5'(p)));
        r_l_p   <= p;
        r_l_tag <= i_tag;
    end

    // log2 by repeated squaring, one fraction bit per stage
    logic              r_q_vld [0:K-1];
    logic [30:0]       r_q_m   [0:K-1];
    logic [15:0]       r_q_f   [0:K-1];
    logic [3:0]        r_q_p   [0:K-1];
    rsc_pkg::t_pow_tag r_q_tag [0:K-1];

    for (genvar k = 0; k < K; k++) begin : g_sq
        logic              a_vld;
        logic [30:0]       a_m;
        logic [15:0]       a_f;
        logic [3:0]        a_p;
        rsc_pkg::t_pow_tag a_tag;
        logic [61:0]       sq;
        logic [31:0]       mm;

        if (k == 0) begin : g_first
            assign a_vld = r_l_vld;
            assign a_m   = r_l_m;
            assign a_f   = '0;
            assign a_p   = r_l_p;
            assign a_tag = r_l_tag;
        end else begin : g_next
            assign a_vld = r_q_vld[k-1];
            assign a_m   = r_q_m[k-1];
            assign a_f   = r_q_f[k-1];
            assign a_p   = r_q_p[k-1];
            assign a_tag = r_q_tag[k-1];
        end

        assign sq = 62'(a_m) * 62'(a_m);
        assign mm = sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[k] <= 1'b0;
            end else begin
                r_q_vld[k] <= a_vld;
            end
            r_q_m[k]   <= mm[31] ? mm[31:1] : mm[30:0];
            r_q_f[k]   <= {a_f[14:0], mm[31]};
            r_q_p[k]   <= a_p;
            r_q_tag[k] <= a_tag;
        end
    end

    // scale by exponent
    logic              r_y_vld;
    logic [23:0]       r_y;
    rsc_pkg::t_pow_tag r_y_tag;

    always_ff @(posedge i_clk) begin
        logic [19:0] mag;
        logic [35:0] prod;
        mag  = 20'({4'd15 - r_q_p[K-1], 16'd0}) - 20'(r_q_f[K-1]);
        prod = 36'(mag) * 36'(i_e);
        if (!i_rst_n) begin
            r_y_vld <= 1'b0;
        end else begin
            r_y_vld <= r_q_vld[K-1];
        end
        r_y     <= prod[35:12];
        r_y_tag <= r_q_tag[K-1];
    end

    // exp2 of the negated fraction, one factor per stage
    logic              r_x_vld [0:K-1];
    logic [30:0]       r_x_r   [0:K-1];
    logic [23:0]       r_x_y   [0:K-1];
    rsc_pkg::t_pow_tag r_x_tag [0:K-1];

    for (genvar k = 0; k < K; k++) begin : g_ex
        localparam logic [30:0] C = rsc_pkg::exp_const(k + 1);
        logic              a_vld;
        logic [30:0]       a_r;
        logic [23:0]       a_y;
        rsc_pkg::t_pow_tag a_tag;
        logic [61:0]       prod;

        if (k == 0) begin : g_first
            assign a_vld = r_y_vld;
            assign a_r   = 31'd1 << 30;
            assign a_y   = r_y;
            assign a_tag = r_y_tag;
        end else begin : g_next
            assign a_vld = r_x_vld[k-1];
            assign a_r   = r_x_r[k-1];
            assign a_y   = r_x_y[k-1];
            assign a_tag = r_x_tag[k-1];
        end

        assign prod = 62'(a_r) * 62'(C);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_x_vld[k] <= 1'b0;
            end else begin
                r_x_vld[k] <= a_vld;
            end
            r_x_r[k]   <= a_y[15-k] ? prod[60:30] : a_r;
            r_x_y[k]   <= a_y;
            r_x_tag[k] <= a_tag;
        end
    end

    // integer shift, Q1.15 and bypass select
    logic        r_f_vld;
    logic [15:0] r_f_shared;
    logic [15:0] r_f_res;

    always_ff @(posedge i_clk) begin
        logic [7:0]  q;
        logic [30:0] sh;
        q  = r_x_y[K-1][23:16];
        sh = (q >= 8'd31) ? '0 : (r_x_r[K-1] >> q[4:0]);
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_x_vld[K-1];
        end
        r_f_shared <= r_x_tag[K-1].shared;
        r_f_res    <= r_x_tag[K-1].bypass ? r_x_tag[K-1].shifted
                                          : rsc_pkg::sat_one(sh[30:15]);
    end

    assign o_vld    = r_f_vld;
    assign o_shared = r_f_shared;
    assign o_result = r_f_res;

endmodule

// ===== hw/rtl/residency_importance_score_core.sv =====
`timescale 1ns / 1ps
// Importance scoring pipeline. One item is taken every clock cycle and busy never rises;
// each item passes the input stage, the square root (8 stages), the three score stages
// and the power unit, whose log2 and exp2 each spend one multiplier stage per fraction
// bit (16 + 16). The result cannot be held back: it must be taken in the strobe cycle.
// The user must write registers through the cfg port only while no item is in flight;
// the block does not enforce this. Written values act on items started after the write.
module residency_importance_score_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_screen_coverage,
    input  logic [15:0] i_gameplay_mark,
    input  logic [15:0] i_distance,
    output logic        o_strobe,
    output logic [15:0] o_shared_importance,
    output logic [15:0] o_subsystem_importance,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_distance_weight;
    logic [15:0] r_gain;
    logic [15:0] r_bias;
    logic [15:0] r_exponent;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_weight <= '0;
            r_gain            <= 16'd4096;
            r_bias            <= '0;
            r_exponent        <= rsc_pkg::EXP_UNITY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rsc_pkg::REG_DIST_WEIGHT: r_distance_weight <= i_cfg_data;
                rsc_pkg::REG_GAIN:        r_gain            <= i_cfg_data;
                rsc_pkg::REG_BIAS:        r_bias            <= i_cfg_data;
                rsc_pkg::REG_EXPONENT:    r_exponent        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage: saturate, distance attenuation
    logic        r_a_vld;
    logic [15:0] r_a_cov;
    logic [15:0] r_a_gm;
    logic [15:0] r_a_att;

    always_ff @(posedge i_clk) begin
        logic [31:0] wd;
        wd = 32'(rsc_pkg::sat_one(r_distance_weight)) * 32'(rsc_pkg::sat_one(i_distance));
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start & ~busy;
        end
        r_a_cov <= rsc_pkg::sat_one(i_screen_coverage);
        r_a_gm  <= rsc_pkg::sat_one(i_gameplay_mark);
        r_a_att <= rsc_pkg::ONE_Q15 - wd[30:15];
    end

    logic               s_vld;
    logic [15:0]        s_root;
    rsc_pkg::t_sqrt_tag s_tag;

    rsc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_a_vld),
        .i_n     ({1'b0, r_a_cov, 15'd0}),
        .i_tag   ('{gm: r_a_gm, att: r_a_att}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_tag   (s_tag)
    );

    // shared importance
    logic        r_c_vld;
    logic [15:0] r_c_shared;
    logic [15:0] r_c_att;

    always_ff @(posedge i_clk) begin
        logic [15:0] ext;
        logic [31:0] pr;
        logic [16:0] sum;
        ext = rsc_pkg::sat_one(s_root);
        pr  = 32'(s_tag.gm) * 32'(rsc_pkg::ONE_Q15 - ext);
        sum = 17'(ext) + 17'(pr[30:15]);
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= s_vld;
        end
        r_c_shared <= (sum > 17'(rsc_pkg::ONE_Q15)) ? rsc_pkg::ONE_Q15 : sum[15:0];
        r_c_att    <= s_tag.att;
    end

    // attenuation
    logic        r_d_vld;
    logic [15:0] r_d_shared;
    logic [15:0] r_d_w;

    always_ff @(posedge i_clk) begin
        logic [31:0] pr;
        pr = 32'(r_c_shared) * 32'(r_c_att);
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_shared <= r_c_shared;
        r_d_w      <= rsc_pkg::sat_one(pr[30:15]);
    end

    // gain and bias
    logic              r_e_vld;
    logic [15:0]       r_e_x;
    logic [15:0]       r_e_exp;
    rsc_pkg::t_pow_tag r_e_tag;

    always_ff @(posedge i_clk) begin
        logic signed [34:0] sw;
        logic signed [34:0] sg;
        logic signed [34:0] sb;
        logic signed [34:0] t;
        logic signed [34:0] q;
        logic [15:0]        shf;
        logic [15:0]        e;
        sw = {19'd0, r_d_w};
        sg = {{19{r_gain[15]}}, r_gain};
        sb = {{7{r_bias[15]}}, r_bias, 12'd0};
        t  = sw * sg + sb;
        q  = t >>> 12;
        if (q[34]) begin
            shf = '0;
        end else if (q > 35'sd32768) begin
            shf = rsc_pkg::ONE_Q15;
        end else begin
            shf = q[15:0];
        end
        e = (r_exponent == '0) ? rsc_pkg::EXP_MIN : r_exponent;
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_x   <= shf;
        r_e_exp <= e;
        r_e_tag <= '{shared: r_d_shared, shifted: shf,
                     bypass: (e == rsc_pkg::EXP_UNITY) || (shf == '0)};
    end

    rsc_pow u_pow (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_e_vld),
        .i_x      (r_e_x),
        .i_e      (r_e_exp),
        .i_tag    (r_e_tag),
        .o_vld    (o_strobe),
        .o_shared (o_shared_importance),
        .o_result (o_subsystem_importance)
    );

endmodule

// ===== hw/rtl/rsc_chk.sv =====
`timescale 1ns / 1ps
module rsc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [15:0] o_shared_importance,
    input logic [15:0] o_subsystem_importance,
    input logic        o_cfg_ready
);

    a_strobe_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, rsc_pkg::LATENCY))
        else $error("result without a matching item");

    a_shared_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_shared_importance <= rsc_pkg::ONE_Q15))
        else $error("shared importance above one");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_subsystem_importance <= rsc_pkg::ONE_Q15))
        else $error("subsystem importance above one");

    a_always_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("block refused an item or a write");

endmodule

bind residency_importance_score_core rsc_chk u_rsc_chk (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .start                  (start),
    .busy                   (busy),
    .o_strobe               (o_strobe),
    .o_shared_importance    (o_shared_importance),
    .o_subsystem_importance (o_subsystem_importance),
    .o_cfg_ready            (o_cfg_ready)
);
